// ===== hw/rtl/dfe_pkg.sv =====
`timescale 1ns / 1ps
package dfe_pkg;

   localparam int unsigned MARK_LEN = 5;

   typedef logic [2:0] count_type;
   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic      is_end;
      count_type prefix_cnt;
      byte_type  data;
   } cmd_type;

   function automatic byte_type start_mark(input count_type idx);
      byte_type b;
      b = 8'h00;
      unique case (idx)
         3'd0: b = 8'h64;
         3'd1: b = 8'h61;
         3'd2: b = 8'h6E;
         3'd3: b = 8'h3C;
         3'd4: b = 8'h60;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic byte_type end_mark(input count_type idx);
      byte_type b;
      b = 8'h00;
      unique case (idx)
         3'd0: b = 8'h60;
         3'd1: b = 8'h3E;
         3'd2: b = 8'h64;
         3'd3: b = 8'h61;
         3'd4: b = 8'h6E;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== hw/rtl/dfe_front.sv =====
`timescale 1ns / 1ps
module dfe_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_take,
   input  logic [7:0]       in_byte,
   output logic             cmd_push,
   output dfe_pkg::cmd_type cmd
);
   import dfe_pkg::*;

   logic      inside_ff, inside_in;
   count_type held_ff, held_in;
   count_type n;
   count_type n_next;

   always_comb begin
      n         = (held_ff >= count_type'(MARK_LEN)) ? 3'd0 : held_ff;
      n_next    = n + 3'd1;
      inside_in = inside_ff;
      held_in   = held_ff;
      cmd_push  = 1'b0;
      cmd       = '{is_end: 1'b0, prefix_cnt: n, data: in_byte};
      if (in_take) begin
         if (!inside_ff) begin
            if (in_byte == start_mark(n)) begin
               if (n_next == count_type'(MARK_LEN)) begin
                  inside_in = 1'b1;
                  held_in   = 3'd0;
               end else begin
                  held_in = n_next;
               end
            end else begin
               held_in = 3'd0;
            end
         end else if (in_byte == end_mark(n)) begin
            if (n_next == count_type'(MARK_LEN)) begin
               inside_in = 1'b0;
               held_in   = 3'd0;
               cmd_push  = 1'b1;
               cmd       = '{is_end: 1'b1, prefix_cnt: 3'd0, data: 8'h00};
            end else begin
               held_in = n_next;
            end
         end else begin
            held_in  = 3'd0;
            cmd_push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         held_ff   <= 3'd0;
      end else begin
         inside_ff <= inside_in;
         held_ff   <= held_in;
      end
   end

endmodule

// ===== hw/rtl/dfe_cmd_fifo.sv =====
`timescale 1ns / 1ps
module dfe_cmd_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dfe_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output dfe_pkg::cmd_type head_data
);
   import dfe_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/dfe_back.sv =====
`timescale 1ns / 1ps
module dfe_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  dfe_pkg::cmd_type head_data,
   output logic             cmd_pop,
   output logic             out_valid,
   input  logic             out_take,
   output logic [7:0]       out_payload_byte,
   output logic             out_frame_end,
   output logic             out_run_last
);
   import dfe_pkg::*;

   logic      active_ff, active_in;
   count_type idx_ff, idx_in;
   cmd_type   cur_ff, cur_in;
   logic      valid_ff, valid_in;
   byte_type  byte_ff, byte_in;
   logic      end_ff, end_in;
   logic      last_ff, last_in;
   logic      out_free, emit, is_last, load;

   assign out_free = !valid_ff || out_take;
   assign emit     = active_ff && out_free;
   assign is_last  = cur_ff.is_end || (idx_ff == cur_ff.prefix_cnt);
   assign load     = head_valid && (!active_ff || (emit && is_last));
   assign cmd_pop  = load;

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      cur_in    = cur_ff;
      if (emit) begin
         idx_in = idx_ff + 3'd1;
         if (is_last) begin
            active_in = 1'b0;
         end
      end
      if (load) begin
         active_in = 1'b1;
         idx_in    = 3'd0;
         cur_in    = head_data;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      if (out_take) begin
         valid_in = 1'b0;
      end
      if (emit) begin
         valid_in = 1'b1;
         end_in   = cur_ff.is_end;
         last_in  = is_last;
         if (cur_ff.is_end) begin
            byte_in = 8'h00;
         end else if (is_last) begin
            byte_in = cur_ff.data;
         end else begin
            byte_in = end_mark(idx_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      byte_ff <= byte_in;
      end_ff  <= end_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= 3'd0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         valid_ff  <= valid_in;
      end
   end

   assign out_valid        = valid_ff;
   assign out_payload_byte = byte_ff;
   assign out_frame_end    = end_ff;
   assign out_run_last     = last_ff;

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff <= cur_ff.prefix_cnt) || cur_ff.is_end)
      else $error("prefix index ran past held count");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && end_ff) |-> (byte_ff == 8'h00) && last_ff)
      else $error("frame end result carries data or is not last");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_take) |=> valid_ff)
      else $error("result lost while stalled");
`endif

endmodule

// ===== hw/rtl/delimited_frame_extractor.sv =====
`timescale 1ns / 1ps
// Start/end delimiter deframer.
// Input channel: present a received byte on req_rx_byte with req_push; it
// transfers on a rising edge where req_push is high and req_full is low.
// Result channel: while rsp_empty is low the oldest result is on the rsp_
// ports; it transfers on a rising edge where rsp_pop is high.
// Bytes outside a frame are matched against the start marker and dropped.
// Inside a frame, end-marker prefixes are held; a broken prefix is released
// as payload followed by the new byte, and a full end marker gives one
// result with rsp_frame_end set. rsp_run_last marks the last result of a byte.
// The first result of a byte passes the queue, the held-command register
// and the output register. The result stage emits one result per cycle
// while the receiver takes results; a byte releases one to five results,
// and one that gives no result pushes nothing. A CMD_DEPTH-entry queue
// between classifier and result stage keeps input flowing in long runs.
// Reset clears the frame state, the queue and the output stage.
// When the receiver stalls, the output holds, the queue fills, then req_full.
module delimited_frame_extractor #(
   parameter int unsigned CMD_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_frame_end,
   output logic       rsp_run_last
);
   import dfe_pkg::*;

   logic    in_take;
   logic    cmd_push, cmd_pop, head_valid, out_valid;
   cmd_type cmd, head_data;

   assign in_take = req_push && !req_full;

   dfe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_take  (in_take),
      .in_byte  (req_rx_byte),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   dfe_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd),
      .full       (req_full),
      .pop        (cmd_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   dfe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_data        (head_data),
      .cmd_pop          (cmd_pop),
      .out_valid        (out_valid),
      .out_take         (rsp_pop),
      .out_payload_byte (rsp_payload_byte),
      .out_frame_end    (rsp_frame_end),
      .out_run_last     (rsp_run_last)
   );

   assign rsp_empty = !out_valid;

endmodule
